// ----- rtl/core/sus_pkg.sv -----
// sus_pkg: shared types, sizes and status codes for the sorted unique set
// no dependencies; used by the interfaces, the cell and the top level
package sus_pkg;

    // number of entries in the store
    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [31:0] t_value;
    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;

    // field types of the channels
    typedef logic       t_req_type;
    typedef logic [2:0] t_status;
    typedef logic [4:0] t_position;
    typedef logic [5:0] t_count;

    localparam t_req_type REQ_INSERT = 1'b0;
    localparam t_req_type REQ_DELETE = 1'b1;

    localparam t_status ST_INSERTED = 3'd0;
    localparam t_status ST_PRESENT  = 3'd1;
    localparam t_status ST_REMOVED  = 3'd2;
    localparam t_status ST_ABSENT   = 3'd3;
    localparam t_status ST_FULL     = 3'd4;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

// ----- rtl/core/sus_req_if.sv -----
// sus_req_if: request channel (valid/ready, request type and value)
// depends on sus_pkg
interface sus_req_if;
    logic               valid;
    logic               ready;
    sus_pkg::t_req_type req_type;
    sus_pkg::t_value    value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

// ----- rtl/core/sus_rsp_if.sv -----
// sus_rsp_if: response channel (valid/ready, status, position and count)
// depends on sus_pkg
interface sus_rsp_if;
    logic               valid;
    logic               ready;
    sus_pkg::t_status   status;
    sus_pkg::t_position position;
    sus_pkg::t_count    count;

    modport source (output valid, output status, output position, output count, input ready);
    modport sink   (input valid, input status, input position, input count, output ready);
endinterface

// ----- rtl/core/sus_cell.sv -----
// sus_cell: one slot of the sorted store, compares against the request and shifts
// depends on sus_pkg
module sus_cell (
    input  logic               i_clk,
    input  logic               i_occ,
    input  sus_pkg::t_value    i_value,
    input  sus_pkg::t_cell_ctl i_ctl,
    input  logic               i_left_lt,
    input  sus_pkg::t_value    i_left_val,
    input  sus_pkg::t_value    i_right_val,
    output logic               o_lt,
    output logic               o_eq,
    output sus_pkg::t_value    o_val
);

    sus_pkg::t_value r_val;
    sus_pkg::t_value n_val;

    assign o_lt  = i_occ && (r_val < i_value);
    assign o_eq  = i_occ && (r_val == i_value);
    assign o_val = r_val;

    // smaller entries stay put, the rest move one slot
    always_comb begin
        n_val = r_val;
        if (i_ctl.ins && !o_lt) begin
            n_val = i_left_lt ? i_value : i_left_val;
        end else if (i_ctl.del && !o_lt) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ----- rtl/core/sorted_unique_set_core.sv -----
// sorted_unique_set_core: sorted set of distinct signed values in a row of cells
// depends on sus_pkg, sus_req_if, sus_rsp_if and sus_cell
//
//  channel  dir  fields                      transfer when
//  i_req    in   req_type, value             i_req.valid && i_req.ready
//  o_rsp    out  status, position, count     o_rsp.valid && o_rsp.ready
//
// a request is registered in S_IDLE on transfer; in S_EXEC it is compared in
// all cells at once, the row is shifted and the result register is loaded.
// S_EXEC waits while an earlier result is still held.
// reset (i_rst_n low at a clock edge) empties the set; cell contents are not
// cleared, occupancy follows from the stored count.
module sorted_unique_set_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sus_req_if.sink        i_req,
    sus_rsp_if.source      o_rsp
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // registered request
    sus_pkg::t_req_type r_req_type;
    sus_pkg::t_value    r_value;

    // number of stored values
    sus_pkg::t_cnt r_count;
    sus_pkg::t_cnt n_count;

    // result register
    logic               r_out_valid;
    sus_pkg::t_status   r_status;
    sus_pkg::t_position r_position;
    sus_pkg::t_count    r_out_count;
    sus_pkg::t_status   n_status;
    sus_pkg::t_position n_position;

    // row of cells
    logic [sus_pkg::CAPACITY-1:0]    occ;
    logic [sus_pkg::CAPACITY-1:0]    lt;
    logic [sus_pkg::CAPACITY-1:0]    eq;
    logic [sus_pkg::CAPACITY-1:0]    left_lt;
    logic [sus_pkg::CAPACITY-1:0]    bnd;
    sus_pkg::t_value                 cell_val [sus_pkg::CAPACITY];
    sus_pkg::t_cell_ctl              ctl;

    logic          fire;
    logic          hit;
    logic          full;
    logic          do_ins;
    logic          do_del;
    sus_pkg::t_idx idx;

    // one request at a time; the result register frees the request side
    assign i_req.ready = (r_state == S_IDLE);
    assign fire        = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    assign hit    = |eq;
    assign full   = (r_count == sus_pkg::t_cnt'(sus_pkg::CAPACITY));
    assign do_ins = fire && (r_req_type == sus_pkg::REQ_INSERT) && !hit && !full;
    assign do_del = fire && (r_req_type == sus_pkg::REQ_DELETE) && hit;

    assign ctl.ins = do_ins;
    assign ctl.del = do_del;

    genvar g;
    generate
        for (g = 0; g < sus_pkg::CAPACITY; g++) begin : g_cell
            // slots below the count hold values
            assign occ[g] = (sus_pkg::t_cnt'(g) < r_count);

            // a virtual smaller neighbour sits left of the first slot
            if (g == 0) begin : g_first
                assign left_lt[g] = 1'b1;
            end else begin : g_rest
                assign left_lt[g] = lt[g-1];
            end

            // first slot that is not below the request value
            assign bnd[g] = left_lt[g] && !lt[g];

            sus_cell u_cell (
                .i_clk       (i_clk),
                .i_occ       (occ[g]),
                .i_value     (r_value),
                .i_ctl       (ctl),
                .i_left_lt   (left_lt[g]),
                .i_left_val  ((g == 0) ? r_value : cell_val[(g == 0) ? 0 : g-1]),
                .i_right_val ((g == sus_pkg::CAPACITY-1) ? r_value
                              : cell_val[(g == sus_pkg::CAPACITY-1) ? g : g+1]),
                .o_lt        (lt[g]),
                .o_eq        (eq[g]),
                .o_val       (cell_val[g])
            );
        end
    endgenerate

    // boundary is one-hot or empty, so an or of indexes encodes it
    always_comb begin
        idx = '0;
        for (int i = 0; i < sus_pkg::CAPACITY; i++) begin
            if (bnd[i]) begin
                idx = idx | sus_pkg::t_idx'(i);
            end
        end
    end

    // status, position and new count
    always_comb begin
        n_count    = r_count;
        n_position = '0;
        if (r_req_type == sus_pkg::REQ_INSERT) begin
            if (hit) begin
                n_status   = sus_pkg::ST_PRESENT;
                n_position = sus_pkg::t_position'(idx);
            end else if (full) begin
                n_status   = sus_pkg::ST_FULL;
            end else begin
                n_status   = sus_pkg::ST_INSERTED;
                n_position = sus_pkg::t_position'(idx);
                n_count    = r_count + sus_pkg::t_cnt'(1);
            end
        end else begin
            if (hit) begin
                n_status   = sus_pkg::ST_REMOVED;
                n_position = sus_pkg::t_position'(idx);
                n_count    = r_count - sus_pkg::t_cnt'(1);
            end else begin
                n_status   = sus_pkg::ST_ABSENT;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (fire) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req_type <= i_req.req_type;
            r_value    <= i_req.value;
        end
        if (fire) begin
            r_status    <= n_status;
            r_position  <= n_position;
            r_out_count <= sus_pkg::t_count'(n_count);
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_status;
    assign o_rsp.position = r_position;
    assign o_rsp.count    = r_out_count;

endmodule
